// ===== hdl/ear_clipping_triangulator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ear clipping triangulator assertion macros
// Shared property templates for the assertions at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EAR_CLIPPING_TRIANGULATOR_TOP_DEFINES_SVH
`define EAR_CLIPPING_TRIANGULATOR_TOP_DEFINES_SVH

// same-cycle implication
`define ECLIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECLIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/eclip_pkg.sv =====
// ----------------------------------------------------------------------------
// eclip_pkg
// Types and constants shared by the ear clipping triangulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eclip_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int COORD_BITS_DEF   = 16;
    localparam int MIN_POLY         = 3;

    localparam logic [1:0] OUT_TRI   = 2'd0;
    localparam logic [1:0] OUT_NOEAR = 2'd1;
    localparam logic [1:0] OUT_FEW   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_SCAN_B,
        S_FIND_A,
        S_FIND_C,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_CAP_C,
        S_CONV,
        S_CONV_CHK,
        S_SCAN_J,
        S_CAP_P,
        S_IN1,
        S_IN1_CHK,
        S_IN2,
        S_IN2_CHK,
        S_IN3,
        S_IN3_CHK,
        S_EMIT_TRI,
        S_EMIT_FEW,
        S_EMIT_NOEAR
    } state_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_A,
        CAP_B,
        CAP_C,
        CAP_P
    } cap_t;

    // orientation operand order (p1, p2, p3)
    typedef enum logic [1:0] {
        OS_BCA,
        OS_PAB,
        OS_PBC,
        OS_PCA
    } osel_t;

    typedef struct packed {
        logic       wr_en;
        cap_t       cap;
        osel_t      osel;
        logic       ogo;
        logic       out_load;
        logic       out_tri;
        logic [1:0] outcome;
        logic       last_res;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/eclip_ram.sv =====
// ----------------------------------------------------------------------------
// eclip_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eclip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/eclip_ctrl.sv =====
// ----------------------------------------------------------------------------
// eclip_ctrl
// Controller: vertex loading, remaining-vertex bookkeeping and ear search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eclip_ctrl import eclip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            is_last_vertex,
    output logic                                 in_ready,
    input  wire stat_t                           stat,
    output cmd_t                                 cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]      wr_addr,
    output logic [$clog2(MAX_VERTICES)-1:0]      rd_addr
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] MINC = CW'(MIN_POLY);

    state_t                  state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic [MAX_VERTICES-1:0] alive_reg, alive_next;
    logic [CW-1:0]           bi_reg, bi_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [IW-1:0]           walk_reg, walk_next;
    logic [IW-1:0]           a_reg, a_next;
    logic [IW-1:0]           c_reg, c_next;

    logic [IW-1:0] bidx, jidx, prv, nxt;
    logic          b_hit, j_skip;

    assign bidx   = bi_reg[IW-1:0];
    assign jidx   = j_reg[IW-1:0];
    assign prv    = (walk_reg == '0) ? IW'(n_reg - 1'b1) : IW'(walk_reg - 1'b1);
    assign nxt    = (CW'(walk_reg) == n_reg - 1'b1) ? '0 : IW'(walk_reg + 1'b1);
    assign b_hit  = (bi_reg != n_reg) && alive_reg[bidx];
    assign j_skip = !alive_reg[jidx] || (jidx == a_reg) || (jidx == bidx)
                    || (jidx == c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            rem_reg   <= '0;
            alive_reg <= '0;
            bi_reg    <= '0;
            j_reg     <= '0;
            walk_reg  <= '0;
            a_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            rem_reg   <= rem_next;
            alive_reg <= alive_next;
            bi_reg    <= bi_next;
            j_reg     <= j_next;
            walk_reg  <= walk_next;
            a_reg     <= a_next;
            c_reg     <= c_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && is_last_vertex)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = (n_reg < MINC) ? S_EMIT_FEW : S_SCAN_B;
            end
            S_SCAN_B:
            begin
                if (bi_reg == n_reg)
                begin
                    state_next = S_EMIT_NOEAR;
                end
                else if (b_hit)
                begin
                    state_next = S_FIND_A;
                end
            end
            S_FIND_A:
            begin
                if (alive_reg[prv])
                begin
                    state_next = S_FIND_C;
                end
            end
            S_FIND_C:
            begin
                if (alive_reg[nxt])
                begin
                    state_next = S_RD_A;
                end
            end
            S_RD_A:     state_next = S_RD_B;
            S_RD_B:     state_next = S_RD_C;
            S_RD_C:     state_next = S_CAP_C;
            S_CAP_C:    state_next = S_CONV;
            S_CONV:     state_next = S_CONV_CHK;
            S_CONV_CHK: state_next = stat.neg ? S_SCAN_J : S_SCAN_B;
            S_SCAN_J:
            begin
                if (j_reg == n_reg)
                begin
                    state_next = S_EMIT_TRI;
                end
                else if (!j_skip)
                begin
                    state_next = S_CAP_P;
                end
            end
            S_CAP_P:    state_next = S_IN1;
            S_IN1:      state_next = S_IN1_CHK;
            S_IN1_CHK:  state_next = stat.neg ? S_IN2 : S_SCAN_J;
            S_IN2:      state_next = S_IN2_CHK;
            S_IN2_CHK:  state_next = stat.neg ? S_IN3 : S_SCAN_J;
            S_IN3:      state_next = S_IN3_CHK;
            S_IN3_CHK:  state_next = stat.neg ? S_SCAN_B : S_SCAN_J;
            S_EMIT_TRI:
            begin
                if (stat.out_free)
                begin
                    state_next = (rem_reg == MINC) ? S_IDLE : S_SCAN_B;
                end
            end
            S_EMIT_FEW, S_EMIT_NOEAR:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // bookkeeping registers
    always_comb
    begin
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        alive_next = alive_reg;
        bi_next    = bi_reg;
        j_next     = j_reg;
        walk_next  = walk_reg;
        a_next     = a_reg;
        c_next     = c_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cnt_reg < MAXC)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (is_last_vertex)
                    begin
                        n_next   = (cnt_reg < MAXC) ? cnt_reg + 1'b1 : cnt_reg;
                        cnt_next = '0;
                    end
                end
            end
            S_START:
            begin
                rem_next = n_reg;
                bi_next  = '0;
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    alive_next[i] = (CW'(i) < n_reg);
                end
            end
            S_SCAN_B:
            begin
                if (b_hit)
                begin
                    walk_next = bidx;
                end
                else if (bi_reg != n_reg)
                begin
                    bi_next = bi_reg + 1'b1;
                end
            end
            S_FIND_A:
            begin
                walk_next = prv;
                if (alive_reg[prv])
                begin
                    a_next    = prv;
                    walk_next = bidx;
                end
            end
            S_FIND_C:
            begin
                walk_next = nxt;
                if (alive_reg[nxt])
                begin
                    c_next = nxt;
                end
            end
            S_CONV_CHK:
            begin
                if (stat.neg)
                begin
                    j_next = '0;
                end
                else
                begin
                    bi_next = bi_reg + 1'b1;
                end
            end
            S_SCAN_J:
            begin
                if (j_reg != n_reg && j_skip)
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_IN1_CHK, S_IN2_CHK:
            begin
                if (!stat.neg)
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_IN3_CHK:
            begin
                if (stat.neg)
                begin
                    bi_next = bi_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_EMIT_TRI:
            begin
                if (stat.out_free)
                begin
                    alive_next[bidx] = 1'b0;
                    rem_next         = rem_reg - 1'b1;
                    bi_next          = '0;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.cap      = CAP_NONE;
        cmd.osel     = OS_BCA;
        cmd.outcome  = OUT_TRI;
        rd_addr      = '0;
        wr_addr      = cnt_reg[IW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.wr_en  = in_valid && (cnt_reg < MAXC);
            end
            S_RD_A:
            begin
                rd_addr = a_reg;
            end
            S_RD_B:
            begin
                rd_addr = bidx;
                cmd.cap = CAP_A;
            end
            S_RD_C:
            begin
                rd_addr = c_reg;
                cmd.cap = CAP_B;
            end
            S_CAP_C:
            begin
                cmd.cap = CAP_C;
            end
            S_CONV:
            begin
                cmd.ogo  = 1'b1;
                cmd.osel = OS_BCA;
            end
            S_SCAN_J:
            begin
                rd_addr = jidx;
            end
            S_CAP_P:
            begin
                cmd.cap = CAP_P;
            end
            S_IN1:
            begin
                cmd.ogo  = 1'b1;
                cmd.osel = OS_PAB;
            end
            S_IN2:
            begin
                cmd.ogo  = 1'b1;
                cmd.osel = OS_PBC;
            end
            S_IN3:
            begin
                cmd.ogo  = 1'b1;
                cmd.osel = OS_PCA;
            end
            S_EMIT_TRI:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_tri  = 1'b1;
                cmd.outcome  = OUT_TRI;
                cmd.last_res = (rem_reg == MINC);
            end
            S_EMIT_FEW:
            begin
                cmd.out_load = stat.out_free;
                cmd.outcome  = OUT_FEW;
                cmd.last_res = 1'b1;
            end
            S_EMIT_NOEAR:
            begin
                cmd.out_load = stat.out_free;
                cmd.outcome  = OUT_NOEAR;
                cmd.last_res = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/eclip_dp.sv =====
// ----------------------------------------------------------------------------
// eclip_dp
// Datapath: vertex store, corner registers, orientation unit, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eclip_dp import eclip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire cmd_t                               cmd,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]    wr_addr,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]    rd_addr,
    input  wire logic signed [COORD_BITS-1:0]       vertex_x,
    input  wire logic signed [COORD_BITS-1:0]       vertex_y,
    input  wire logic                               out_ready,
    output stat_t                                   stat,
    output logic                                    out_valid,
    output logic signed [COORD_BITS-1:0]            first_x,
    output logic signed [COORD_BITS-1:0]            first_y,
    output logic signed [COORD_BITS-1:0]            ear_x,
    output logic signed [COORD_BITS-1:0]            ear_y,
    output logic signed [COORD_BITS-1:0]            third_x,
    output logic signed [COORD_BITS-1:0]            third_y,
    output logic [1:0]                              outcome,
    output logic                                    is_final
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic [COORD_BITS-1:0] rx, ry;

    eclip_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_xram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (vertex_x),
        .raddr (rd_addr),
        .rdata (rx)
    );

    eclip_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_yram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (vertex_y),
        .raddr (rd_addr),
        .rdata (ry)
    );

    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, px_reg, py_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.cap)
            CAP_A:
            begin
                ax_reg <= rx;
                ay_reg <= ry;
            end
            CAP_B:
            begin
                bx_reg <= rx;
                by_reg <= ry;
            end
            CAP_C:
            begin
                cx_reg <= rx;
                cy_reg <= ry;
            end
            CAP_P:
            begin
                px_reg <= rx;
                py_reg <= ry;
            end
            default:
            begin
                ax_reg <= ax_reg;
            end
        endcase
    end

    // orientation: sign of (p1 - p3) x (p2 - p3)
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3;
    logic signed [DW-1:0]         dx1, dy1, dx2, dy2;
    logic signed [PW-1:0]         prod1_reg, prod1_next, prod2_reg, prod2_next;

    always_comb
    begin
        case (cmd.osel)
            OS_BCA:
            begin
                x1 = bx_reg; y1 = by_reg; x2 = cx_reg; y2 = cy_reg;
                x3 = ax_reg; y3 = ay_reg;
            end
            OS_PAB:
            begin
                x1 = px_reg; y1 = py_reg; x2 = ax_reg; y2 = ay_reg;
                x3 = bx_reg; y3 = by_reg;
            end
            OS_PBC:
            begin
                x1 = px_reg; y1 = py_reg; x2 = bx_reg; y2 = by_reg;
                x3 = cx_reg; y3 = cy_reg;
            end
            OS_PCA:
            begin
                x1 = px_reg; y1 = py_reg; x2 = cx_reg; y2 = cy_reg;
                x3 = ax_reg; y3 = ay_reg;
            end
            default:
            begin
                x1 = bx_reg; y1 = by_reg; x2 = cx_reg; y2 = cy_reg;
                x3 = ax_reg; y3 = ay_reg;
            end
        endcase
        dx1        = DW'(x1) - DW'(x3);
        dy1        = DW'(y1) - DW'(y3);
        dx2        = DW'(x2) - DW'(x3);
        dy2        = DW'(y2) - DW'(y3);
        prod1_next = PW'(dx1) * PW'(dy2);
        prod2_next = PW'(dx2) * PW'(dy1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ogo)
        begin
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
    end

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] fx_reg, fy_reg, ex_reg, ey_reg, tx_reg, ty_reg;
    logic [1:0]                   outcome_reg;
    logic                         final_reg;

    assign out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            fx_reg      <= cmd.out_tri ? ax_reg : '0;
            fy_reg      <= cmd.out_tri ? ay_reg : '0;
            ex_reg      <= cmd.out_tri ? bx_reg : '0;
            ey_reg      <= cmd.out_tri ? by_reg : '0;
            tx_reg      <= cmd.out_tri ? cx_reg : '0;
            ty_reg      <= cmd.out_tri ? cy_reg : '0;
            outcome_reg <= cmd.outcome;
            final_reg   <= cmd.last_res;
        end
    end

    assign stat.neg      = (prod1_reg < prod2_reg);
    assign stat.out_free = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign first_x   = fx_reg;
    assign first_y   = fy_reg;
    assign ear_x     = ex_reg;
    assign ear_y     = ey_reg;
    assign third_x   = tx_reg;
    assign third_y   = ty_reg;
    assign outcome   = outcome_reg;
    assign is_final  = final_reg;

endmodule

`default_nettype wire

// ===== hdl/ear_clipping_triangulator_top.sv =====
// ----------------------------------------------------------------------------
// ear_clipping_triangulator_top
// Ear clipping triangulator for clockwise polygons with integer vertices.
// ----------------------------------------------------------------------------
// Vertices are taken one per cycle and written to the vertex store; vertices
// beyond MAX_VERTICES are dropped. The transfer marked is_last_vertex starts
// clipping and input stays stalled until the polygon's final result has been
// loaded into the output register. Each ear candidate first walks to its
// live neighbors and then gets a turn test, and every other remaining vertex
// is checked against it for lying inside the candidate triangle. The search
// is serialized by the single orientation unit and the single read port of
// the vertex store.
// One triangle result per clipped ear, then either the last triangle carries
// is_final or a status result (no ear, or fewer than three vertices) does.
// fill_color is held for software and does not affect results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ear_clipping_triangulator_top_defines.svh"

module ear_clipping_triangulator_top import eclip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [31:0]                  cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] vertex_x,
    input  wire logic signed [COORD_BITS-1:0] vertex_y,
    input  wire logic                         is_last_vertex,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      first_x,
    output logic signed [COORD_BITS-1:0]      first_y,
    output logic signed [COORD_BITS-1:0]      ear_x,
    output logic signed [COORD_BITS-1:0]      ear_y,
    output logic signed [COORD_BITS-1:0]      third_x,
    output logic signed [COORD_BITS-1:0]      third_y,
    output logic [1:0]                        outcome,
    output logic                              is_final
);

    localparam int IW = $clog2(MAX_VERTICES);

    logic [31:0] fill_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg <= '0;
        end
        else if (cfg_valid)
        begin
            fill_color_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    cmd_t          cmd;
    stat_t         stat;
    logic [IW-1:0] wr_addr, rd_addr;

    eclip_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .is_last_vertex (is_last_vertex),
        .in_ready       (in_ready),
        .stat           (stat),
        .cmd            (cmd),
        .wr_addr        (wr_addr),
        .rd_addr        (rd_addr)
    );

    eclip_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .vertex_x  (vertex_x),
        .vertex_y  (vertex_y),
        .out_ready (out_ready),
        .stat      (stat),
        .out_valid (out_valid),
        .first_x   (first_x),
        .first_y   (first_y),
        .ear_x     (ear_x),
        .ear_y     (ear_y),
        .third_x   (third_x),
        .third_y   (third_y),
        .outcome   (outcome),
        .is_final  (is_final)
    );

    `ECLIP_ASSERT_NEXT(a_last_stalls, in_valid && in_ready && is_last_vertex, !in_ready, "input not stalled after last vertex")
    `ECLIP_ASSERT_NOW(a_status_final, out_valid && (outcome != OUT_TRI), is_final, "status result not final")
    `ECLIP_ASSERT_NOW(a_status_zero, out_valid && (outcome != OUT_TRI), (first_x == '0) && (ear_y == '0) && (third_x == '0), "status result carries coordinates")

endmodule

`default_nettype wire
